/* hw/rtl/i2cmbs_pkg.sv */
// Shared types, phase codes and constants of the I2C master bit sequencer.
`default_nettype none
package i2cmbs_pkg;

    localparam int PHASE_W = 5;
    localparam int CMD_W   = 3;
    localparam int CFG_W   = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INIT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEND    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RECV    = 3'd5;

    // Configuration register indexes.
    localparam logic REG_UNIT_TICKS = 1'b0;
    localparam logic REG_INIT_UNITS = 1'b1;

    localparam logic [CFG_W-1:0] UNIT_TICKS_RST = 16'd3;
    localparam logic [CFG_W-1:0] INIT_UNITS_RST = 16'd334;

    // Wait lengths in delay units.
    localparam logic [CFG_W-1:0] UNITS_SHORT  = 16'd1;
    localparam logic [CFG_W-1:0] UNITS_MEDIUM = 16'd2;
    localparam logic [CFG_W-1:0] UNITS_LONG   = 16'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Sequencer phases.
    localparam logic [PHASE_W-1:0] PH_IDLE  = 5'd0;
    localparam logic [PHASE_W-1:0] PH_INIT0 = 5'd1;
    localparam logic [PHASE_W-1:0] PH_INIT1 = 5'd2;
    localparam logic [PHASE_W-1:0] PH_ST0   = 5'd3;
    localparam logic [PHASE_W-1:0] PH_ST1   = 5'd4;
    localparam logic [PHASE_W-1:0] PH_ST2   = 5'd5;
    localparam logic [PHASE_W-1:0] PH_SP0   = 5'd6;
    localparam logic [PHASE_W-1:0] PH_SP1   = 5'd7;
    localparam logic [PHASE_W-1:0] PH_SP2   = 5'd8;
    localparam logic [PHASE_W-1:0] PH_RS0   = 5'd9;
    localparam logic [PHASE_W-1:0] PH_RS1   = 5'd10;
    localparam logic [PHASE_W-1:0] PH_RS2   = 5'd11;
    localparam logic [PHASE_W-1:0] PH_RS3   = 5'd12;
    localparam logic [PHASE_W-1:0] PH_TX0   = 5'd13;
    localparam logic [PHASE_W-1:0] PH_TX1   = 5'd14;
    localparam logic [PHASE_W-1:0] PH_TX2   = 5'd15;
    localparam logic [PHASE_W-1:0] PH_TX3   = 5'd16;
    localparam logic [PHASE_W-1:0] PH_TX4   = 5'd17;
    localparam logic [PHASE_W-1:0] PH_TX5   = 5'd18;
    localparam logic [PHASE_W-1:0] PH_TX6   = 5'd19;
    localparam logic [PHASE_W-1:0] PH_TX7   = 5'd20;
    localparam logic [PHASE_W-1:0] PH_RX0   = 5'd21;
    localparam logic [PHASE_W-1:0] PH_RX1   = 5'd22;
    localparam logic [PHASE_W-1:0] PH_RX2   = 5'd23;
    localparam logic [PHASE_W-1:0] PH_RX3   = 5'd24;
    localparam logic [PHASE_W-1:0] PH_RX4   = 5'd25;
    localparam logic [PHASE_W-1:0] PH_RX5   = 5'd26;
    localparam logic [PHASE_W-1:0] PH_RX6   = 5'd27;
    localparam logic [PHASE_W-1:0] PH_RX7   = 5'd28;
    localparam logic [PHASE_W-1:0] PH_RX8   = 5'd29;
    localparam logic [PHASE_W-1:0] PH_END   = 5'd30;

    typedef struct packed {
        logic             kind;
        logic [CMD_W-1:0] command;
        logic [7:0]       tx_byte;
        logic             send_nack;
        logic             sda_sample;
    } in_t;

    typedef struct packed {
        logic       scl_low;
        logic       sda_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_data;
        logic       ack_level;
        logic       rejected;
    } out_t;

    // Input register contents handed to the sequencer core.
    typedef struct packed {
        logic valid;
        in_t  item;
    } stage_t;

    function automatic logic [PHASE_W-1:0] first_phase(input logic [CMD_W-1:0] cmd);
        logic [PHASE_W-1:0] ph;
        case (cmd)
            CMD_INIT:    ph = PH_INIT0;
            CMD_START:   ph = PH_ST0;
            CMD_STOP:    ph = PH_SP0;
            CMD_RESTART: ph = PH_RS0;
            CMD_SEND:    ph = PH_TX0;
            CMD_RECV:    ph = PH_RX0;
            default:     ph = PH_IDLE;
        endcase
        return ph;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/i2cmbs_in_stage.sv */
// Input register stage of the I2C master bit sequencer.
`default_nettype none
module i2cmbs_in_stage (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire i2cmbs_pkg::in_t   s_data,
    input  wire logic              advance,
    output i2cmbs_pkg::stage_t     stage
);

    logic            valid_reg;
    logic            valid_next;
    i2cmbs_pkg::in_t data_reg;

    // The register may refill in the same cycle that the core consumes it.
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = data_reg;

endmodule
`default_nettype wire

/* hw/rtl/i2cmbs_core.sv */
// Sequencer state, configuration registers, pin sequence logic and result register.
`default_nettype none
module i2cmbs_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [i2cmbs_pkg::CFG_W-1:0] cfg_wdata,
    input  wire i2cmbs_pkg::stage_t          stage,
    output logic                             advance,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output i2cmbs_pkg::out_t                 m_data
);

    localparam int CW = i2cmbs_pkg::CFG_W;
    localparam int PW = i2cmbs_pkg::PHASE_W;
    // Upper bound on the chain of phases run on one item without a wait between them.
    localparam int MAX_CHAIN = 4;
    localparam logic [CW-1:0] UNIT_ONE = 16'd1;

    logic [CW-1:0] unit_ticks_reg;
    logic [CW-1:0] init_units_reg;

    logic [PW-1:0] phase_reg,         phase_next;
    logic [CW-1:0] wait_count_reg,    wait_count_next;
    logic [CW-1:0] units_left_reg,    units_left_next;
    logic [3:0]    bit_index_reg,     bit_index_next;
    logic [7:0]    shifter_reg,       shifter_next;
    logic          last_sda_high_reg, last_sda_high_next;
    logic          nack_held_reg,     nack_held_next;
    logic          scl_drive_reg,     scl_drive_next;
    logic          sda_drive_reg,     sda_drive_next;
    logic [7:0]    received_reg,      received_next;
    logic          ack_sample_reg,    ack_sample_next;

    logic             m_valid_reg;
    i2cmbs_pkg::out_t m_data_reg;
    i2cmbs_pkg::out_t result;

    logic [CW-1:0] eff_unit;
    logic          run;
    logic          stop;
    logic          done;
    logic          rej;
    i2cmbs_pkg::in_t item;

    assign item     = stage.item;
    assign advance  = stage.valid && (!m_valid_reg || m_ready);
    assign eff_unit = (unit_ticks_reg == '0) ? UNIT_ONE : unit_ticks_reg;

    always_comb begin
        phase_next         = phase_reg;
        wait_count_next    = wait_count_reg;
        units_left_next    = units_left_reg;
        bit_index_next     = bit_index_reg;
        shifter_next       = shifter_reg;
        last_sda_high_next = last_sda_high_reg;
        nack_held_next     = nack_held_reg;
        scl_drive_next     = scl_drive_reg;
        sda_drive_next     = sda_drive_reg;
        received_next      = received_reg;
        ack_sample_next    = ack_sample_reg;
        run  = 1'b0;
        done = 1'b0;
        rej  = 1'b0;

        if (item.kind) begin
            if (phase_reg != i2cmbs_pkg::PH_IDLE || item.command > i2cmbs_pkg::CMD_RECV) begin
                rej = 1'b1;
            end else begin
                nack_held_next = item.send_nack;
                shifter_next   = item.tx_byte;
                phase_next     = i2cmbs_pkg::first_phase(item.command);
                run            = 1'b1;
            end
        end else if (phase_reg != i2cmbs_pkg::PH_IDLE) begin
            if (units_left_reg == '0) begin
                run = 1'b1;
            end else if (wait_count_reg > UNIT_ONE) begin
                wait_count_next = wait_count_reg - UNIT_ONE;
            end else if (units_left_reg > UNIT_ONE) begin
                units_left_next = units_left_reg - UNIT_ONE;
                wait_count_next = eff_unit;
            end else begin
                units_left_next = '0;
                wait_count_next = '0;
                run             = 1'b1;
            end
        end

        // Each pass runs one phase's actions; a started wait or the return to idle ends the chain.
        stop = !run;
        for (int i = 0; i < MAX_CHAIN; i++) begin
            if (!stop) begin
                case (phase_next)
                    i2cmbs_pkg::PH_INIT0: begin
                        scl_drive_next  = 1'b0;
                        phase_next      = i2cmbs_pkg::PH_INIT1;
                        units_left_next = i2cmbs_pkg::UNITS_MEDIUM;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_INIT1: begin
                        sda_drive_next     = 1'b0;
                        last_sda_high_next = 1'b1;
                        phase_next         = i2cmbs_pkg::PH_END;
                        if (init_units_reg != '0) begin
                            units_left_next = init_units_reg;
                            wait_count_next = eff_unit;
                            stop            = 1'b1;
                        end
                    end
                    i2cmbs_pkg::PH_ST0: begin
                        phase_next      = i2cmbs_pkg::PH_ST1;
                        units_left_next = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_ST1: begin
                        scl_drive_next  = 1'b0;
                        phase_next      = i2cmbs_pkg::PH_ST2;
                        units_left_next = i2cmbs_pkg::UNITS_LONG;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_ST2: begin
                        sda_drive_next     = 1'b1;
                        last_sda_high_next = 1'b0;
                        phase_next         = i2cmbs_pkg::PH_END;
                        units_left_next    = i2cmbs_pkg::UNITS_MEDIUM;
                        wait_count_next    = eff_unit;
                        stop               = 1'b1;
                    end
                    i2cmbs_pkg::PH_SP0, i2cmbs_pkg::PH_RS0: begin
                        scl_drive_next  = 1'b0;
                        phase_next      = (phase_next == i2cmbs_pkg::PH_SP0) ?
                                          i2cmbs_pkg::PH_SP1 : i2cmbs_pkg::PH_RS1;
                        units_left_next = i2cmbs_pkg::UNITS_MEDIUM;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_SP1, i2cmbs_pkg::PH_RS1: begin
                        // Drive SDA to the opposite of the last level that was set.
                        sda_drive_next     = last_sda_high_next;
                        last_sda_high_next = !last_sda_high_next;
                        phase_next         = (phase_next == i2cmbs_pkg::PH_SP1) ?
                                             i2cmbs_pkg::PH_SP2 : i2cmbs_pkg::PH_RS2;
                        units_left_next    = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next    = eff_unit;
                        stop               = 1'b1;
                    end
                    i2cmbs_pkg::PH_SP2: begin
                        sda_drive_next     = 1'b0;
                        last_sda_high_next = 1'b1;
                        phase_next         = i2cmbs_pkg::PH_END;
                        units_left_next    = i2cmbs_pkg::UNITS_LONG;
                        wait_count_next    = eff_unit;
                        stop               = 1'b1;
                    end
                    i2cmbs_pkg::PH_RS2: begin
                        sda_drive_next     = 1'b0;
                        last_sda_high_next = 1'b1;
                        phase_next         = i2cmbs_pkg::PH_RS3;
                        units_left_next    = i2cmbs_pkg::UNITS_MEDIUM;
                        wait_count_next    = eff_unit;
                        stop               = 1'b1;
                    end
                    i2cmbs_pkg::PH_RS3: begin
                        sda_drive_next     = 1'b1;
                        last_sda_high_next = 1'b0;
                        phase_next         = i2cmbs_pkg::PH_END;
                    end
                    i2cmbs_pkg::PH_TX0: begin
                        scl_drive_next  = 1'b1;
                        bit_index_next  = '0;
                        phase_next      = i2cmbs_pkg::PH_TX1;
                        units_left_next = i2cmbs_pkg::UNITS_MEDIUM;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_TX1: begin
                        if (bit_index_next < i2cmbs_pkg::BITS_PER_BYTE) begin
                            sda_drive_next     = !shifter_next[7];
                            last_sda_high_next = shifter_next[7];
                            phase_next         = i2cmbs_pkg::PH_TX2;
                            units_left_next    = i2cmbs_pkg::UNITS_SHORT;
                            wait_count_next    = eff_unit;
                            stop               = 1'b1;
                        end else begin
                            phase_next = i2cmbs_pkg::PH_TX4;
                        end
                    end
                    i2cmbs_pkg::PH_TX2: begin
                        scl_drive_next  = 1'b0;
                        shifter_next    = {shifter_next[6:0], 1'b0};
                        phase_next      = i2cmbs_pkg::PH_TX3;
                        units_left_next = i2cmbs_pkg::UNITS_MEDIUM;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_TX3: begin
                        scl_drive_next  = 1'b1;
                        bit_index_next  = bit_index_next + 4'd1;
                        phase_next      = i2cmbs_pkg::PH_TX1;
                        units_left_next = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_TX4: begin
                        sda_drive_next  = 1'b0;
                        phase_next      = i2cmbs_pkg::PH_TX5;
                        units_left_next = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_TX5: begin
                        scl_drive_next  = 1'b0;
                        phase_next      = i2cmbs_pkg::PH_TX6;
                        units_left_next = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_TX6: begin
                        ack_sample_next = item.sda_sample;
                        phase_next      = i2cmbs_pkg::PH_TX7;
                        units_left_next = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_TX7: begin
                        scl_drive_next  = 1'b1;
                        phase_next      = i2cmbs_pkg::PH_END;
                        units_left_next = i2cmbs_pkg::UNITS_LONG;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_RX0: begin
                        sda_drive_next = 1'b0;
                        bit_index_next = '0;
                        shifter_next   = '0;
                        phase_next     = i2cmbs_pkg::PH_RX1;
                    end
                    i2cmbs_pkg::PH_RX1: begin
                        if (bit_index_next < i2cmbs_pkg::BITS_PER_BYTE) begin
                            shifter_next    = {shifter_next[6:0], 1'b0};
                            phase_next      = i2cmbs_pkg::PH_RX2;
                            units_left_next = i2cmbs_pkg::UNITS_SHORT;
                            wait_count_next = eff_unit;
                            stop            = 1'b1;
                        end else begin
                            phase_next = i2cmbs_pkg::PH_RX5;
                        end
                    end
                    i2cmbs_pkg::PH_RX2: begin
                        scl_drive_next  = 1'b0;
                        phase_next      = i2cmbs_pkg::PH_RX3;
                        units_left_next = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_RX3: begin
                        shifter_next[0] = shifter_next[0] | item.sda_sample;
                        phase_next      = i2cmbs_pkg::PH_RX4;
                        units_left_next = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_RX4: begin
                        scl_drive_next  = 1'b1;
                        bit_index_next  = bit_index_next + 4'd1;
                        phase_next      = i2cmbs_pkg::PH_RX1;
                        units_left_next = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_RX5: begin
                        received_next      = shifter_next;
                        sda_drive_next     = !nack_held_next;
                        last_sda_high_next = nack_held_next;
                        phase_next         = i2cmbs_pkg::PH_RX6;
                        units_left_next    = i2cmbs_pkg::UNITS_SHORT;
                        wait_count_next    = eff_unit;
                        stop               = 1'b1;
                    end
                    i2cmbs_pkg::PH_RX6: begin
                        scl_drive_next  = 1'b0;
                        phase_next      = i2cmbs_pkg::PH_RX7;
                        units_left_next = i2cmbs_pkg::UNITS_MEDIUM;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_RX7: begin
                        scl_drive_next  = 1'b1;
                        phase_next      = i2cmbs_pkg::PH_RX8;
                        units_left_next = i2cmbs_pkg::UNITS_LONG;
                        wait_count_next = eff_unit;
                        stop            = 1'b1;
                    end
                    i2cmbs_pkg::PH_RX8: begin
                        sda_drive_next = 1'b0;
                        phase_next     = i2cmbs_pkg::PH_END;
                    end
                    default: begin
                        phase_next      = i2cmbs_pkg::PH_IDLE;
                        units_left_next = '0;
                        wait_count_next = '0;
                        done            = 1'b1;
                        stop            = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        result.scl_low   = scl_drive_next;
        result.sda_low   = sda_drive_next;
        result.busy_res  = (phase_next != i2cmbs_pkg::PH_IDLE);
        result.done_res  = done;
        result.rx_data   = received_next;
        result.ack_level = ack_sample_next;
        result.rejected  = rej;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_ticks_reg <= i2cmbs_pkg::UNIT_TICKS_RST;
            init_units_reg <= i2cmbs_pkg::INIT_UNITS_RST;
        end else if (cfg_we) begin
            if (cfg_index == i2cmbs_pkg::REG_UNIT_TICKS) begin
                unit_ticks_reg <= cfg_wdata;
            end else if (cfg_index == i2cmbs_pkg::REG_INIT_UNITS) begin
                init_units_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= i2cmbs_pkg::PH_IDLE;
            wait_count_reg    <= '0;
            units_left_reg    <= '0;
            bit_index_reg     <= '0;
            shifter_reg       <= '0;
            last_sda_high_reg <= 1'b1;
            nack_held_reg     <= 1'b0;
            scl_drive_reg     <= 1'b0;
            sda_drive_reg     <= 1'b0;
            received_reg      <= '0;
            ack_sample_reg    <= 1'b1;
        end else if (advance) begin
            phase_reg         <= phase_next;
            wait_count_reg    <= wait_count_next;
            units_left_reg    <= units_left_next;
            bit_index_reg     <= bit_index_next;
            shifter_reg       <= shifter_next;
            last_sda_high_reg <= last_sda_high_next;
            nack_held_reg     <= nack_held_next;
            scl_drive_reg     <= scl_drive_next;
            sda_drive_reg     <= sda_drive_next;
            received_reg      <= received_next;
            ack_sample_reg    <= ack_sample_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A sequence in progress always has a wait under way.
    a_wait_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != i2cmbs_pkg::PH_IDLE) |-> (units_left_reg != '0 && wait_count_reg != '0))
        else $error("busy sequencer without a running wait");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == i2cmbs_pkg::PH_IDLE) |-> (units_left_reg == '0 && wait_count_reg == '0))
        else $error("idle sequencer with wait counters left over");

    a_busy_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (m_valid_reg && m_data_reg.busy_res == (phase_reg != i2cmbs_pkg::PH_IDLE)))
        else $error("busy flag disagrees with the sequencer phase");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && item.kind && phase_reg != i2cmbs_pkg::PH_IDLE) |=>
        (m_data_reg.rejected && $stable(phase_reg)))
        else $error("command while busy was not rejected");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.done_res) |-> (!m_data_reg.busy_res && !m_data_reg.rejected))
        else $error("done reported with busy or rejected");

endmodule
`default_nettype wire

/* hw/rtl/i2c_master_bit_sequencer_top.sv */
// Top level of the I2C master bit sequencer.
//
// Each request on the s_ channel is either one time tick or one command
// (init, start, stop, restart, send byte, receive byte). For every request
// exactly one result leaves on the m_ channel: the SCL and SDA drive levels,
// busy and done flags, the last received byte, the last ACK sample and a
// rejected flag for a command that arrived while a sequence was running or had an unknown code.
// Waits are counted in ticks: one delay unit is unit_ticks ticks, or one tick if unit_ticks is 0.
// A request is registered in the input register when it is accepted, and its
// result is registered in the result register when the core consumes it; m_valid
// then rises. One request per cycle is sustained while m_ready is high; each
// request's update is combinational phase and counter logic between those registers.
// When the receiver stalls, the result register holds and the input register
// still takes one more request, after which s_ready falls until m_ready.
// Synchronous active-low reset idles the sequencer, releases both lines and
// loads unit_ticks = 3 and init_units = 334. Configuration is written through
// cfg_we, cfg_index and cfg_wdata; the user must write only while no request is
// in flight (not enforced by the block); a write during a wait affects later units.
`default_nettype none
module i2c_master_bit_sequencer_top (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [i2cmbs_pkg::CFG_W-1:0] cfg_wdata,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire i2cmbs_pkg::in_t             s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output i2cmbs_pkg::out_t                 m_data
);

    i2cmbs_pkg::stage_t stage;
    logic               advance;

    i2cmbs_in_stage u_in_stage (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .advance (advance),
        .stage   (stage)
    );

    i2cmbs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .stage     (stage),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire
